// ----- design/telemetry_byte_stuffed_deframer_core_assert.svh -----
// assertion macros for the byte-stuffed deframer
`ifndef TELEMETRY_BYTE_STUFFED_DEFRAMER_CORE_ASSERT_SVH
`define TELEMETRY_BYTE_STUFFED_DEFRAMER_CORE_ASSERT_SVH

`ifndef SYNTH

`define TBSD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("deframer assertion failed");

`define TBSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`else

`define TBSD_ASSERT(lbl, clk, rst_n, prop)

`define TBSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/tbsd_pkg.sv -----
`timescale 1ns / 1ps

package tbsd_pkg;

    localparam int OUT_LIMIT = 16;
    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 4;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_FRAME,
        S_ESC,
        S_RD,
        S_LD
    } t_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIXED_MODE = 3'd0,
        REG_FRAME_LEN  = 3'd1,
        REG_FLAG       = 3'd2,
        REG_ESCAPE     = 3'd3,
        REG_MASK       = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic put;
        logic esc;
        logic clr;
        logic emit;
        logic load;
        logic rd_inc;
    } t_dp_cmd;

    typedef struct packed {
        logic flag_hit;
        logic esc_hit;
        logic fixed;
        logic reached;
        logic out_free;
        logic last;
    } t_dp_sta;

endpackage

// ----- design/tbsd_in_if.sv -----
`timescale 1ns / 1ps

interface tbsd_in_if;
    import tbsd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- design/tbsd_out_if.sv -----
`timescale 1ns / 1ps

interface tbsd_out_if;
    import tbsd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic [IDX_W-1:0]  byte_index;
    logic [LEN_W-1:0]  frame_len;
    logic              last;

    modport source (output valid, output frame_byte, output byte_index,
                    output frame_len, output last, input ready);
    modport sink (input valid, input frame_byte, input byte_index,
                  input frame_len, input last, output ready);
endinterface

// ----- design/tbsd_ram.sv -----
`timescale 1ns / 1ps

module tbsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/tbsd_ctrl.sv -----
`timescale 1ns / 1ps

`include "telemetry_byte_stuffed_deframer_core_assert.svh"

module tbsd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  tbsd_pkg::t_dp_sta i_sta,
    output tbsd_pkg::t_dp_cmd o_cmd
);
    import tbsd_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;
    logic    w_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        o_ready = 1'b0;
        w_acc   = 1'b0;
        unique case (r_state) inside
            S_IDLE, S_START, S_FRAME, S_ESC: begin
                o_ready = 1'b1;
                w_acc   = i_valid;
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                if (i_sta.out_free) begin
                    cmd.load = 1'b1;
                    if (i_sta.last) begin
                        n_state = S_IDLE;
                    end else begin
                        cmd.rd_inc = 1'b1;
                        n_state    = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_acc) begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_sta.flag_hit) begin
                        cmd.clr = 1'b1;
                        n_state = S_START;
                    end
                end
                S_START: begin
                    if (i_sta.flag_hit) begin
                        cmd.clr = i_sta.fixed;
                    end else begin
                        cmd.put = 1'b1;
                    end
                    n_state = S_FRAME;
                end
                S_FRAME: begin
                    if (i_sta.esc_hit) begin
                        n_state = S_ESC;
                    end else if (i_sta.flag_hit) begin
                        if (i_sta.fixed) begin
                            cmd.clr = 1'b1;
                        end else begin
                            cmd.emit = 1'b1;
                        end
                    end else begin
                        cmd.put = 1'b1;
                    end
                end
                S_ESC: begin
                    cmd.put = 1'b1;
                    cmd.esc = 1'b1;
                    n_state = S_FRAME;
                end
                default: begin
                end
            endcase
            // count-based end of frame
            if (i_sta.fixed && i_sta.reached) begin
                cmd.emit = 1'b1;
            end
            if (cmd.emit) begin
                n_state = S_RD;
            end
        end
    end

    assign o_cmd = cmd;

    `TBSD_ASSERT_NEXT(a_emit_starts_drain, i_clk, i_rst_n, cmd.emit, r_state == S_RD)
    `TBSD_ASSERT_NEXT(a_last_ends_drain, i_clk, i_rst_n, cmd.load && i_sta.last, r_state == S_IDLE)
    `TBSD_ASSERT(a_put_not_clr, i_clk, i_rst_n, !(cmd.put && cmd.clr))
    `TBSD_ASSERT(a_no_accept_drain, i_clk, i_rst_n, !((cmd.put || cmd.emit) && (cmd.load || cmd.rd_inc)))
endmodule

// ----- design/tbsd_datapath.sv -----
`timescale 1ns / 1ps

module tbsd_datapath #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tbsd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tbsd_pkg::BYTE_W-1:0]      i_cfg_data,
    input  logic [tbsd_pkg::BYTE_W-1:0]      i_rx_byte,
    input  tbsd_pkg::t_dp_cmd                i_cmd,
    output tbsd_pkg::t_dp_sta                o_sta,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [tbsd_pkg::BYTE_W-1:0]      o_frame_byte,
    output logic [tbsd_pkg::IDX_W-1:0]       o_byte_index,
    output logic [tbsd_pkg::LEN_W-1:0]       o_frame_len,
    output logic                             o_last
);
    import tbsd_pkg::*;

    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int AW = $clog2(BUFFER_DEPTH);

    logic              r_fixed;
    logic [LEN_W-1:0]  r_flen;
    logic [BYTE_W-1:0] r_flag;
    logic [BYTE_W-1:0] r_esc;
    logic [BYTE_W-1:0] r_mask;

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [LEN_W-1:0]  r_len;
    logic [IDX_W-1:0]  r_rd_idx;

    logic              r_ov;
    logic [BYTE_W-1:0] r_fb;
    logic [IDX_W-1:0]  r_bi;
    logic [LEN_W-1:0]  r_fl;
    logic              r_last;

    logic              w_we;
    logic [BYTE_W-1:0] w_wdata;
    logic [BYTE_W-1:0] w_rdata;
    logic [CW-1:0]     w_target;
    logic [LEN_W-1:0]  w_len_post;
    logic              w_last;
    logic              w_empty;
    logic              w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fixed <= 1'b0;
            r_flen  <= LEN_W'(9);
            r_flag  <= BYTE_W'(126);
            r_esc   <= BYTE_W'(125);
            r_mask  <= BYTE_W'(32);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FIXED_MODE: r_fixed <= i_cfg_data[0];
                REG_FRAME_LEN:  r_flen  <= i_cfg_data[LEN_W-1:0];
                REG_FLAG:       r_flag  <= i_cfg_data;
                REG_ESCAPE:     r_esc   <= i_cfg_data;
                REG_MASK:       r_mask  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_we    = i_cmd.put && (r_count < CW'(BUFFER_DEPTH));
        w_wdata = i_cmd.esc ? (i_rx_byte ^ r_mask) : i_rx_byte;

        if (i_cmd.clr) begin
            n_count = '0;
        end else if (w_we) begin
            n_count = r_count + CW'(1);
        end else begin
            n_count = r_count;
        end

        if (r_flen == '0) begin
            w_target = CW'(1);
        end else if (32'(r_flen) > BUFFER_DEPTH) begin
            w_target = CW'(BUFFER_DEPTH);
        end else begin
            w_target = CW'(r_flen);
        end

        if (32'(n_count) >= OUT_LIMIT) begin
            w_len_post = LEN_W'(OUT_LIMIT);
        end else begin
            w_len_post = LEN_W'(n_count);
        end

        w_empty    = (r_len == '0);
        w_last     = w_empty || (({1'b0, r_rd_idx} + LEN_W'(1)) == r_len);
        w_out_free = !r_ov || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_len    <= '0;
            r_rd_idx <= '0;
        end else begin
            if (i_cmd.emit) begin
                r_count  <= '0;
                r_len    <= w_len_post;
                r_rd_idx <= '0;
            end else begin
                r_count <= n_count;
                if (i_cmd.rd_inc) begin
                    r_rd_idx <= r_rd_idx + IDX_W'(1);
                end
            end
        end
    end

    tbsd_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(BUFFER_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(w_wdata),
        .i_raddr(AW'(r_rd_idx)),
        .o_rdata(w_rdata)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fb   <= w_empty ? '0 : w_rdata;
            r_bi   <= r_rd_idx;
            r_fl   <= r_len;
            r_last <= w_last;
        end
    end

    assign o_sta.flag_hit = (i_rx_byte == r_flag);
    assign o_sta.esc_hit  = (i_rx_byte == r_esc);
    assign o_sta.fixed    = r_fixed;
    assign o_sta.reached  = (n_count >= w_target);
    assign o_sta.out_free = w_out_free;
    assign o_sta.last     = w_last;

    assign o_out_valid  = r_ov;
    assign o_frame_byte = r_fb;
    assign o_byte_index = r_bi;
    assign o_frame_len  = r_fl;
    assign o_last       = r_last;
endmodule

// ----- design/telemetry_byte_stuffed_deframer_core.sv -----
`timescale 1ns / 1ps

// a received byte is taken while the controller parses; the request that closes a frame
// sends it to S_RD, then S_LD, which puts the first result in the output register
// throughput: one received byte per cycle while parsing; a frame drains one result per
// S_RD/S_LD pass (store read port, then a free output register), input held meanwhile
// reset: synchronous active low; registers back to defaults, idle, count zero
// frame store is not cleared, only entries written since the last frame are read
module telemetry_byte_stuffed_deframer_core #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tbsd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tbsd_pkg::BYTE_W-1:0]    i_cfg_data,
    tbsd_in_if.sink                        i_rx,
    tbsd_out_if.source                     o_frm
);
    import tbsd_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sta w_sta;
    logic    w_ready;

    tbsd_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_rx.valid),
        .o_ready(w_ready),
        .i_sta  (w_sta),
        .o_cmd  (w_cmd)
    );

    tbsd_datapath #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_rx_byte   (i_rx.rx_byte),
        .i_cmd       (w_cmd),
        .o_sta       (w_sta),
        .i_out_ready (o_frm.ready),
        .o_out_valid (o_frm.valid),
        .o_frame_byte(o_frm.frame_byte),
        .o_byte_index(o_frm.byte_index),
        .o_frame_len (o_frm.frame_len),
        .o_last      (o_frm.last)
    );

    assign i_rx.ready = w_ready;
endmodule

// ----- bench/telemetry_byte_stuffed_deframer_core_check.sv -----
`timescale 1ns / 1ps

module telemetry_byte_stuffed_deframer_core_check #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tbsd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tbsd_pkg::BYTE_W-1:0]    i_cfg_data,
    tbsd_in_if                             i_rx,
    tbsd_out_if                            i_frm,
    output int                             o_fail_count,
    output int                             o_pending
);
    import tbsd_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic [IDX_W-1:0]  byte_index;
        logic [LEN_W-1:0]  frame_len;
        logic              last;
    } t_frame_result;

    t_frame_result frame_results_due[$];
    t_frame_result want;
    t_frame_result got;

    logic              fixed_mode;
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] flag_byte;
    logic [BYTE_W-1:0] escape_byte;
    logic [BYTE_W-1:0] escape_mask;

    t_state            rx_phase;
    int unsigned       held;
    logic [BYTE_W-1:0] held_bytes [BUFFER_DEPTH];
    int                fails = 0;

    assign o_fail_count = fails;

    task automatic hold_byte(input logic [BYTE_W-1:0] b);
        if (held < BUFFER_DEPTH) begin
            held_bytes[held] = b;
            held++;
        end
    endtask

    task automatic release_frame();
        int unsigned n;
        t_frame_result r;
        n = (held > OUT_LIMIT) ? OUT_LIMIT : held;
        held = 0;
        rx_phase = S_IDLE;
        if (n == 0) begin
            r = '0;
            r.last = 1'b1;
            frame_results_due.push_back(r);
        end else begin
            for (int unsigned k = 0; k < n; k++) begin
                r.frame_byte = held_bytes[k];
                r.byte_index = IDX_W'(k);
                r.frame_len  = LEN_W'(n);
                r.last       = (k + 1 == n);
                frame_results_due.push_back(r);
            end
        end
    endtask

    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        int unsigned goal;
        case (rx_phase)
            S_START: begin
                if (b == flag_byte) begin
                    if (fixed_mode) held = 0;
                end else begin
                    hold_byte(b);
                end
                rx_phase = S_FRAME;
            end
            S_FRAME: begin
                if (b == escape_byte) begin
                    rx_phase = S_ESC;
                end else if (b == flag_byte) begin
                    if (fixed_mode) held = 0;
                    else release_frame();
                end else begin
                    hold_byte(b);
                end
            end
            S_ESC: begin
                hold_byte(b ^ escape_mask);
                rx_phase = S_FRAME;
            end
            default: begin
                if (b == flag_byte) begin
                    held = 0;
                    rx_phase = S_START;
                end
            end
        endcase
        if (fixed_mode) begin
            goal = frame_length;
            if (goal == 0) goal = 1;
            if (goal > BUFFER_DEPTH) goal = BUFFER_DEPTH;
            if (held >= goal) release_frame();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fixed_mode   = 1'b0;
            frame_length = 5'd9;
            flag_byte    = 8'h7E;
            escape_byte  = 8'h7D;
            escape_mask  = 8'h20;
            rx_phase     = S_IDLE;
            held         = 0;
            frame_results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FIXED_MODE: fixed_mode   = i_cfg_data[0];
                    REG_FRAME_LEN:  frame_length = i_cfg_data[LEN_W-1:0];
                    REG_FLAG:       flag_byte    = i_cfg_data;
                    REG_ESCAPE:     escape_byte  = i_cfg_data;
                    REG_MASK:       escape_mask  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_frm.valid && i_frm.ready) begin
                got.frame_byte = i_frm.frame_byte;
                got.byte_index = i_frm.byte_index;
                got.frame_len  = i_frm.frame_len;
                got.last       = i_frm.last;
                if (frame_results_due.size() == 0) begin
                    fails++;
                    $display("%0t: none due: byte %h index %0d len %0d last %0d",
                             $time, got.frame_byte, got.byte_index, got.frame_len, got.last);
                end else begin
                    want = frame_results_due.pop_front();
                    if (got.frame_byte !== want.frame_byte || got.byte_index !== want.byte_index
                        || got.frame_len !== want.frame_len || got.last !== want.last) begin
                        fails++;
                        $display("%0t: mismatch: expected %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                                 $time, want.frame_byte, want.byte_index, want.frame_len,
                                 want.last, got.frame_byte, got.byte_index, got.frame_len,
                                 got.last);
                    end
                end
            end
            if (i_rx.valid && i_rx.ready) deframe_byte(i_rx.rx_byte);
        end
        o_pending = frame_results_due.size();
    end

endmodule

// ----- bench/telemetry_byte_stuffed_deframer_core_test.sv -----
`timescale 1ns / 1ps

module telemetry_byte_stuffed_deframer_core_test;
    import tbsd_pkg::*;

    // idle noise, empty frame, raw escape as first byte, stuffed flag and escape
    localparam logic [0:19][7:0] OPENING_BYTES = {
        8'h00, 8'hFF,
        8'h7E, 8'h7E, 8'h7E,
        8'h7E, 8'h7D, 8'h41, 8'h7D, 8'h5E, 8'h7D, 8'h5D, 8'hFF, 8'h00, 8'h7E,
        8'h7E, 8'h01, 8'h7D, 8'h7E, 8'h7E
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [BYTE_W-1:0]    cfg_data;

    int idle_pct  = 0;
    int stall_pct = 0;
    int fail_count;
    int results_pending;

    logic              fixed_v;
    logic [BYTE_W-1:0] flag_v;
    logic [BYTE_W-1:0] esc_v;
    logic [BYTE_W-1:0] mask_v;
    int                frame_goal;

    tbsd_in_if  rx_if ();
    tbsd_out_if frm_if ();

    telemetry_byte_stuffed_deframer_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_rx       (rx_if.sink),
        .o_frm      (frm_if.source)
    );

    telemetry_byte_stuffed_deframer_core_check frame_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_rx         (rx_if),
        .i_frm        (frm_if),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("telemetry_byte_stuffed_deframer_core regression: fail");
        $finish;
    end

    always @(negedge i_clk) begin
        frm_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < idle_pct) begin
            rx_if.valid = 1'b0;
            @(negedge i_clk);
        end
        rx_if.valid   = 1'b1;
        rx_if.rx_byte = b;
        do @(posedge i_clk); while (!rx_if.ready);
        @(negedge i_clk);
    endtask

    // wait until the output side is drained and the parser has settled
    task automatic drain();
        rx_if.valid = 1'b0;
        wait (results_pending == 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [BYTE_W-1:0] val);
        cfg_idx  = idx;
        cfg_data = val;
        cfg_we   = 1'b1;
        @(negedge i_clk);
    endtask

    task automatic write_config(input logic fixed, input logic [LEN_W-1:0] len,
                                input logic [BYTE_W-1:0] flag, input logic [BYTE_W-1:0] esc,
                                input logic [BYTE_W-1:0] mask);
        fixed_v = fixed;
        flag_v  = flag;
        esc_v   = esc;
        mask_v  = mask;
        frame_goal = (len == 0) ? 1 : (len > 16) ? 16 : len;
        write_reg(REG_FIXED_MODE, {7'd0, fixed});
        write_reg(REG_FRAME_LEN, {3'd0, len});
        write_reg(REG_FLAG, flag);
        write_reg(REG_ESCAPE, esc);
        write_reg(REG_MASK, mask);
        cfg_we = 1'b0;
    endtask

    // opening flag, n payload bytes stuffed where needed, optional closing flag
    task automatic send_frame(input int n, input bit close);
        logic [BYTE_W-1:0] p;
        send_byte(flag_v);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(7))
                0: p = flag_v;
                1: p = esc_v;
                default: p = BYTE_W'($urandom_range(255));
            endcase
            if (k > 0 && (p == flag_v || p == esc_v || $urandom_range(9) == 0)) begin
                send_byte(esc_v);
                send_byte(p ^ mask_v);
            end else begin
                send_byte(p);
            end
        end
        if (close) send_byte(flag_v);
    endtask

    initial begin
        int  sent;
        int  n;
        bit  paused;

        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = REG_FIXED_MODE;
        cfg_data      = '0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < 20; i++) send_byte(OPENING_BYTES[i]);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_config(1'b0, 5'd9, 8'h7E, 8'h7D, 8'h20);
                    idle_pct = 0;  stall_pct = 0;
                end
                1: begin
                    write_config(1'b1, 5'd16, 8'h7E, 8'h7D, 8'h20);
                    idle_pct = 83; stall_pct = 0;
                end
                2: begin
                    write_config(1'b1, 5'd0, 8'hFF, 8'h00, 8'hFF);
                    idle_pct = 0;  stall_pct = 83;
                end
                3: begin
                    // flag and escape share one value, so frames end by count only
                    write_config(1'b1, 5'd31, 8'h00, 8'h00, 8'h80);
                    idle_pct = 6;  stall_pct = 6;
                end
                4: begin
                    write_config(1'b0, 5'd1, 8'hAA, 8'h55, 8'h01);
                    idle_pct = 0;  stall_pct = 83;
                end
                default: begin
                    write_config(1'b1, 5'd1, 8'h55, 8'hAA, 8'h00);
                    idle_pct = 0;  stall_pct = 0;
                end
            endcase

            // overlong frame fills the store
            if (!fixed_v && ph == 4) send_frame(18, 1'b1);

            sent   = 0;
            paused = 1'b0;
            while (sent < 4) begin
                if ($urandom_range(4) == 0) send_byte(BYTE_W'($urandom_range(255)));
                if (fixed_v)
                    n = ($urandom_range(3) == 0) ? $urandom_range(frame_goal + 2) : frame_goal;
                else
                    n = ($urandom_range(9) == 0) ? $urandom_range(17, 18) : $urandom_range(6);
                send_frame(n, !fixed_v || $urandom_range(3) == 0);
                sent += n;
                if (!paused && sent >= 2) begin
                    rx_if.valid = 1'b0;
                    wait (results_pending == 0);
                    @(negedge i_clk);
                    paused = 1'b1;
                end
            end
        end

        rx_if.valid = 1'b0;
        wait (results_pending == 0);
        repeat (16) @(negedge i_clk);
        if (fail_count == 0)
            $display("telemetry_byte_stuffed_deframer_core regression: pass");
        else
            $display("telemetry_byte_stuffed_deframer_core regression: fail");
        $finish;
    end

endmodule
